// ===== design/knot_span_greville_engine_core_defines.svh =====
// Assertion macros shared by the knot span engine RTL.
// Uses the clk and arst_n names of the module that expands them.
`ifndef KNOT_SPAN_GREVILLE_ENGINE_CORE_DEFINES_SVH
`define KNOT_SPAN_GREVILLE_ENGINE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define KSG_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");
// next-cycle implication
`define KSG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");
`else
`define KSG_ASSERT_IMPL(lbl, ante, cons)
`define KSG_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== design/ksg_pkg.sv =====
// Types, widths and codes of the knot span / Greville point engine.
// No dependencies; used by the top level and the divider.
package ksg_pkg;

	localparam int FUNC_W     = 2;
	localparam int IDX_W      = 6;
	localparam int KNOT_W     = 32;
	localparam int DEG_W      = 3;
	localparam int STAT_W     = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 6;

	// knot sum and divider sizing: 7 knots of 32 bits fit in 36 bits
	localparam int SUM_W     = 36;
	localparam int DIV_BPC   = 6;
	localparam int DIV_STEPS = SUM_W / DIV_BPC;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// function codes
	localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_SPAN   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_COLLOC = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_RSVD   = 2'd3;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_BAD_INDEX = 2'd1;
	localparam logic [STAT_W-1:0] ST_SEARCH    = 2'd2;

	// configuration register indexes and reset values
	localparam logic [CFG_IDX_W-1:0] CFG_DEGREE    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_LAST_KNOT = 1'b1;
	localparam logic [DEG_W-1:0]     DEGREE_RST    = 3'd3;
	localparam logic [IDX_W-1:0]     LAST_KNOT_RST = 6'd7;

	typedef struct packed {
		logic [FUNC_W-1:0]        func;
		logic [IDX_W-1:0]         knot_address;
		logic signed [KNOT_W-1:0] knot_value;
		logic signed [KNOT_W-1:0] query_value;
		logic [IDX_W-1:0]         node_index;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]         span;
		logic signed [KNOT_W-1:0] abscissa;
		logic [STAT_W-1:0]        status;
	} out_item_t;

	// divider request / response
	typedef struct packed {
		logic             start;
		logic [SUM_W-1:0] dividend;
		logic [DEG_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [SUM_W-1:0] quotient;
		logic             rem_nz;
	} div_rsp_t;

endpackage

// ===== design/ksg_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ksg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/ksg_div.sv =====
// Unsigned divider of the knot sum by the degree, several quotient bits a cycle.
// Depends on ksg_pkg and the assertion macro header.
`include "knot_span_greville_engine_core_defines.svh"
module ksg_div (
	input  logic              clk,
	input  logic              arst_n,
	input  ksg_pkg::div_req_t req,
	output ksg_pkg::div_rsp_t rsp
);
	import ksg_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0]     quo_q;
	logic [DEG_W-1:0]     rem_q;
	logic [DEG_W-1:0]     dvs_q;
	logic [SUM_W-1:0]     quo_d;
	logic [DEG_W-1:0]     rem_d;

	// DIV_BPC restoring steps on a narrow remainder
	always_comb begin : div_steps
		logic [DEG_W:0]   part;
		logic [SUM_W-1:0] qw;
		logic [DEG_W-1:0] rw;
		qw = quo_q;
		rw = rem_q;
		for (int i = 0; i < DIV_BPC; i++) begin
			part = {rw, qw[SUM_W-1]};
			qw   = {qw[SUM_W-2:0], 1'b0};
			if (part >= {1'b0, dvs_q}) begin
				part  = part - {1'b0, dvs_q};
				qw[0] = 1'b1;
			end
			rw = part[DEG_W-1:0];
		end
		quo_d = qw;
		rem_d = rw;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			cnt_q <= '0;
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			cnt_q <= cnt_q + DIV_CNT_W'(1);
			quo_q <= quo_d;
			rem_q <= rem_d;
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;
	assign rsp.rem_nz   = (rem_q != '0);

	`KSG_ASSERT_IMPL(a_rem_bound, busy_q, rem_q < dvs_q)
	`KSG_ASSERT_NEXT(a_done_pulse, done_q, !done_q)
	`KSG_ASSERT_IMPL(a_no_restart, req.start, !busy_q)

endmodule

// ===== design/knot_span_greville_engine_core.sv =====
// Knot span / Greville point engine: top level, control FSM and knot store.
// Depends on ksg_pkg, ksg_ram, ksg_div and the assertion macro header.
//
//  channel | direction | handshake            | beat
//  --------+-----------+----------------------+----------------------------
//  in      | in        | in_valid / in_stall  | in_item  (func, knot, query)
//  out     | out       | out_valid / out_stall| out_item (span, abscissa, status)
//  cfg     | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item at a time; an accepted beat stalls the input until its result is
// in the output register. A knot write goes straight to S_DONE. A span query
// checks the upper clamp at knot n+1, then the lower clamp at knot p, else
// bisects with two knot store reads per step. A collocation query first sums
// knots node+1 .. node+degree, starts the divider once and waits on it, then
// runs the span search on the mean. Errors detected at accept skip to S_DONE.
// Reset clears control and configuration only; the knot store has no clear.
// A stalled output holds its beat while the next item is already accepted.
`include "knot_span_greville_engine_core_defines.svh"
module knot_span_greville_engine_core #(
	parameter int KNOT_DEPTH = 64,
	parameter int MAX_DEGREE = 7
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  ksg_pkg::in_item_t                   in_item,
	output logic                                out_valid,
	input  logic                                out_stall,
	output ksg_pkg::out_item_t                  out_item,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ksg_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ksg_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import ksg_pkg::*;

	localparam int AW = $clog2(KNOT_DEPTH);
	localparam int SW = $clog2(KNOT_DEPTH + 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_SUM,
		S_DIV_GO,
		S_DIV_WAIT,
		S_HI,
		S_LO,
		S_MID_A,
		S_MID_B,
		S_EVAL,
		S_DONE
	} state_t;

	state_t    state_q, state_d;
	logic      out_valid_q;
	out_item_t out_item_q;

	logic [DEG_W-1:0] degree_q;
	logic [IDX_W-1:0] last_q;

	// datapath registers
	logic signed [KNOT_W-1:0] u_q;
	logic signed [KNOT_W-1:0] kmid_q;
	logic [IDX_W-1:0]         node_q;
	logic [IDX_W-1:0]         lo_q, hi_q, mid_q;
	logic [SW-1:0]            steps_q;
	logic [DEG_W-1:0]         cnt_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic                     neg_q;
	out_item_t                res_q;

	logic                     in_acc;
	logic                     cfg_bad, node_bad;
	logic [IDX_W-1:0]         n_plus1, n_idx, mid_init;
	logic [IDX_W:0]           init_sum, nxt_sum;
	logic [IDX_W-1:0]         lo_nxt, hi_nxt, mid_nxt;
	logic                     below, cont;
	logic [IDX_W-1:0]         rd_idx;
	logic                     res_ld;
	out_item_t                res_d;
	logic                     ram_we;
	logic [KNOT_W-1:0]        ram_rdata;
	logic signed [KNOT_W-1:0] rd_k;
	div_req_t                 div_req;
	div_rsp_t                 div_rsp;

	assign in_acc    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;
	assign cfg_ready = 1'b1;
	assign rd_k      = $signed(ram_rdata);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= DEGREE_RST;
			last_q   <= LAST_KNOT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_DEGREE:    degree_q <= cfg_data[DEG_W-1:0];
				CFG_LAST_KNOT: last_q   <= cfg_data[IDX_W-1:0];
				default:       ;
			endcase
		end
	end

	// configuration and node range checks, span bounds
	assign cfg_bad = (degree_q == '0) || (32'(degree_q) > MAX_DEGREE)
		|| (32'(last_q) >= KNOT_DEPTH)
		|| ({1'b0, last_q} < {3'b000, degree_q, 1'b1});
	assign node_bad = ({1'b0, in_item.node_index} + {4'b0000, degree_q}) > {1'b0, last_q};
	assign n_plus1  = last_q - {3'b000, degree_q};
	assign n_idx    = n_plus1 - IDX_W'(1);
	assign init_sum = {4'b0000, degree_q} + {1'b0, n_plus1};
	assign mid_init = init_sum[IDX_W:1];

	// bisection step
	assign below   = (u_q < kmid_q);
	assign cont    = below || (u_q >= rd_k);
	assign lo_nxt  = below ? lo_q : mid_q;
	assign hi_nxt  = below ? mid_q : hi_q;
	assign nxt_sum = {1'b0, lo_nxt} + {1'b0, hi_nxt};
	assign mid_nxt = nxt_sum[IDX_W:1];

	// next state, read address, result
	always_comb begin
		state_d          = state_q;
		res_ld           = 1'b0;
		res_d            = '0;
		rd_idx           = mid_q;
		div_req.start    = 1'b0;
		div_req.dividend = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
		div_req.divisor  = degree_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					priority if (in_item.func == FUNC_WRITE) begin
						res_ld  = 1'b1;
						state_d = S_DONE;
					end else if (in_item.func == FUNC_RSVD || cfg_bad) begin
						res_ld       = 1'b1;
						res_d.status = ST_BAD_INDEX;
						state_d      = S_DONE;
					end else if (in_item.func == FUNC_SPAN) begin
						state_d = S_HI;
					end else if (node_bad) begin
						res_ld       = 1'b1;
						res_d.status = ST_BAD_INDEX;
						state_d      = S_DONE;
					end else begin
						state_d = S_SUM;
					end
				end
			end
			S_SUM: begin
				rd_idx = node_q + IDX_W'(1) + {3'b000, cnt_q};
				if (cnt_q == degree_q) begin
					state_d = S_DIV_GO;
				end
			end
			S_DIV_GO: begin
				div_req.start = 1'b1;
				state_d       = S_DIV_WAIT;
			end
			S_DIV_WAIT: begin
				if (div_rsp.done) begin
					state_d = S_HI;
				end
			end
			S_HI: begin
				rd_idx  = n_plus1;
				state_d = S_LO;
			end
			S_LO: begin
				// upper clamp against knot n+1
				rd_idx = IDX_W'(degree_q);
				if (u_q >= rd_k) begin
					res_ld         = 1'b1;
					res_d.span     = n_idx;
					res_d.abscissa = u_q;
					state_d        = S_DONE;
				end else begin
					state_d = S_MID_A;
				end
			end
			S_MID_A: begin
				// lower clamp against knot p
				rd_idx = mid_q;
				if (u_q <= rd_k) begin
					res_ld         = 1'b1;
					res_d.span     = IDX_W'(degree_q);
					res_d.abscissa = u_q;
					state_d        = S_DONE;
				end else begin
					state_d = S_MID_B;
				end
			end
			S_MID_B: begin
				rd_idx  = mid_q + IDX_W'(1);
				state_d = S_EVAL;
			end
			S_EVAL: begin
				rd_idx = mid_nxt;
				if (!cont) begin
					res_ld         = 1'b1;
					res_d.span     = mid_q;
					res_d.abscissa = u_q;
					state_d        = S_DONE;
				end else if (steps_q == SW'(KNOT_DEPTH) || mid_nxt == mid_q) begin
					res_ld       = 1'b1;
					res_d.status = ST_SEARCH;
					state_d      = S_DONE;
				end else begin
					state_d = S_MID_B;
				end
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			out_item_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DONE && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
				out_item_q  <= res_q;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (res_ld) begin
			res_q <= res_d;
		end
		unique case (state_q)
			S_IDLE: begin
				u_q    <= in_item.query_value;
				node_q <= in_item.node_index;
				cnt_q  <= '0;
				sum_q  <= '0;
			end
			S_SUM: begin
				cnt_q <= cnt_q + DEG_W'(1);
				if (cnt_q != '0) begin
					sum_q <= sum_q + {{(SUM_W - KNOT_W){rd_k[KNOT_W-1]}}, rd_k};
				end
			end
			S_DIV_GO: neg_q <= sum_q[SUM_W-1];
			S_DIV_WAIT: begin
				// floored mean from magnitude quotient
				if (div_rsp.done) begin
					u_q <= neg_q
						? $signed(~div_rsp.quotient[KNOT_W-1:0]
							+ KNOT_W'(!div_rsp.rem_nz))
						: $signed(div_rsp.quotient[KNOT_W-1:0]);
				end
			end
			S_HI: begin
				lo_q    <= IDX_W'(degree_q);
				hi_q    <= n_plus1;
				mid_q   <= mid_init;
				steps_q <= '0;
			end
			S_MID_B: kmid_q <= rd_k;
			S_EVAL: begin
				if (cont && steps_q != SW'(KNOT_DEPTH) && mid_nxt != mid_q) begin
					lo_q    <= lo_nxt;
					hi_q    <= hi_nxt;
					mid_q   <= mid_nxt;
					steps_q <= steps_q + SW'(1);
				end
			end
			default: ;
		endcase
	end

	// knot store
	assign ram_we = in_acc && (in_item.func == FUNC_WRITE)
		&& (32'(in_item.knot_address) < KNOT_DEPTH);

	ksg_ram #(
		.WIDTH(KNOT_W),
		.DEPTH(KNOT_DEPTH)
	) u_knot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(AW'(in_item.knot_address)),
		.wdata(in_item.knot_value),
		.raddr(AW'(rd_idx)),
		.rdata(ram_rdata)
	);

	ksg_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	`KSG_ASSERT_IMPL(a_bracket, state_q == S_EVAL, (lo_q <= mid_q) && (mid_q < hi_q))
	`KSG_ASSERT_IMPL(a_sum_count, state_q == S_SUM, cnt_q <= degree_q)
	`KSG_ASSERT_NEXT(a_out_load, (state_q == S_DONE) && (!out_valid || !out_stall), out_valid)

endmodule

// ===== bench/tb_knot_span_greville_engine_core.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the knot span / Greville point engine: knot writes, span and
// collocation queries over many degree / knot count settings, checked against a local model.
// Depends on ksg_pkg and knot_span_greville_engine_core.
module tb_knot_span_greville_engine_core;
	import ksg_pkg::*;

	localparam int KNOT_SLOTS  = 64;
	localparam int MAX_DEG     = 7;
	localparam int ITEM_GOAL   = 1650;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam logic signed [KNOT_W-1:0] Q_MIN = 32'sh8000_0000;
	localparam logic signed [KNOT_W-1:0] Q_MAX = 32'sh7FFF_FFFF;

	typedef enum {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;
	typedef enum {VEC_CLAMPED, VEC_OPEN, VEC_FULL_RANGE, VEC_SCRAMBLED} vec_kind_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_item;
	logic out_valid;
	logic out_stall;
	out_item_t out_item;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// local copy of the engine state
	logic signed [KNOT_W-1:0] knot_mem [0:KNOT_SLOTS-1];
	logic [DEG_W-1:0] deg_cfg = DEGREE_RST;
	logic [IDX_W-1:0] last_cfg = LAST_KNOT_RST;

	out_item_t span_results_due[$];
	int fail_count = 0;
	int items_sent = 0;
	int cycle_count = 0;
	int burst_left = 0;
	bit sender_steady = 0;

	knot_span_greville_engine_core #(
		.KNOT_DEPTH(KNOT_SLOTS),
		.MAX_DEGREE(MAX_DEG)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ---------------- model ----------------

	function automatic longint knot_rd(input int k);
		if (k >= KNOT_SLOTS) return 0;
		return longint'(knot_mem[k]);
	endfunction

	// clamp, then bisect [p, n+1]; gives up when mid stops moving or the step limit is hit
	function automatic logic [STAT_W-1:0] bisect_span(input int n, input int p, input longint u,
			output int sp);
		int lo, hi, mid, prev, steps;
		sp = 0;
		if (u >= knot_rd(n + 1)) begin
			sp = n;
			return ST_OK;
		end
		if (u <= knot_rd(p)) begin
			sp = p;
			return ST_OK;
		end
		lo = p;
		hi = n + 1;
		mid = (lo + hi) / 2;
		steps = 0;
		while (u < knot_rd(mid) || u >= knot_rd(mid + 1)) begin
			if (steps >= KNOT_SLOTS) return ST_SEARCH;
			steps++;
			prev = mid;
			if (u < knot_rd(mid))
				hi = mid;
			else
				lo = mid;
			mid = (lo + hi) / 2;
			if (mid == prev) return ST_SEARCH;
		end
		sp = mid;
		return ST_OK;
	endfunction

	// expected result of one beat; knot writes update the local store
	function automatic out_item_t compute_span_result(input in_item_t it);
		out_item_t res;
		int p, m, n, sp, node;
		longint u, sum, q;
		logic [STAT_W-1:0] st;
		res = '0;
		p = deg_cfg;
		m = last_cfg;
		node = it.node_index;
		u = longint'(it.query_value);
		if (it.func == FUNC_WRITE) begin
			knot_mem[it.knot_address] = it.knot_value;
			return res;
		end
		if (it.func == FUNC_RSVD || p == 0 || p > MAX_DEG || m >= KNOT_SLOTS || m < 2 * p + 1) begin
			res.status = ST_BAD_INDEX;
			return res;
		end
		n = m - p - 1;
		if (it.func == FUNC_COLLOC) begin
			if (node + p > m) begin
				res.status = ST_BAD_INDEX;
				return res;
			end
			sum = 0;
			for (int j = 1; j <= p; j++)
				sum += knot_rd(node + j);
			// floored mean
			q = sum / p;
			if (sum % p != 0 && sum < 0)
				q -= 1;
			u = q;
		end
		st = bisect_span(n, p, u, sp);
		if (st != ST_OK) begin
			res.status = st;
			return res;
		end
		res.span = sp[IDX_W-1:0];
		res.abscissa = u[KNOT_W-1:0];
		res.status = ST_OK;
		return res;
	endfunction

	// ---------------- checking ----------------

	task automatic report_mismatch(input string what);
		$display("ERROR at %0t ns: %s", $time, what);
		fail_count++;
	endtask

	always @(posedge clk) begin
		out_item_t due;
		if (arst_n && out_valid && !out_stall) begin
			if (span_results_due.size() == 0) begin
				report_mismatch($sformatf("unexpected beat: span %0d abscissa %0d status %0d",
					out_item.span, out_item.abscissa, out_item.status));
			end else begin
				due = span_results_due.pop_front();
				if (out_item.span !== due.span)
					report_mismatch($sformatf("span got %0d want %0d", out_item.span, due.span));
				if (out_item.abscissa !== due.abscissa)
					report_mismatch($sformatf("abscissa got %0d want %0d",
						out_item.abscissa, due.abscissa));
				if (out_item.status !== due.status)
					report_mismatch($sformatf("status got %0d want %0d",
						out_item.status, due.status));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Some tests failed");
			$finish;
		end
	end

	// output back-pressure, a randomly picked mode every segment
	initial begin
		stall_mode_t mode;
		int seg_len;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			mode = stall_mode_t'($urandom_range(0, 3));
			seg_len = $urandom_range(20, 200);
			for (int c = 0; c < seg_len; c++) begin
				@(posedge clk);
				case (mode)
					STALL_NONE: out_stall <= 1'b0;
					STALL_COIN: out_stall <= ($urandom_range(0, 1) == 1);
					STALL_PERIODIC: out_stall <= ((c % 7) < 3);
					default: out_stall <= ($urandom_range(0, 9) < 8);
				endcase
			end
		end
	end

	// ---------------- stimulus helpers ----------------

	function automatic in_item_t rand_item();
		logic [95:0] r;
		in_item_t it;
		r = {$urandom, $urandom, $urandom};
		it = r[$bits(in_item_t)-1:0];
		return it;
	endfunction

	// one input beat, sent in bursts with random gaps
	task automatic send_item(input in_item_t it);
		int gap;
		if (burst_left == 0) begin
			gap = sender_steady ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		in_item <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		span_results_due.push_back(compute_span_result(it));
		items_sent++;
	endtask

	task automatic knot_write(input int addr, input logic signed [KNOT_W-1:0] val);
		in_item_t it;
		it = rand_item();
		it.func = FUNC_WRITE;
		it.knot_address = addr[IDX_W-1:0];
		it.knot_value = val;
		send_item(it);
	endtask

	task automatic span_query(input longint u);
		in_item_t it;
		it = rand_item();
		it.func = FUNC_SPAN;
		it.query_value = u[KNOT_W-1:0];
		send_item(it);
	endtask

	task automatic colloc_query(input int node);
		in_item_t it;
		it = rand_item();
		it.func = FUNC_COLLOC;
		it.node_index = node[IDX_W-1:0];
		send_item(it);
	endtask

	task automatic reserved_op();
		in_item_t it;
		it = rand_item();
		it.func = FUNC_RSVD;
		send_item(it);
	endtask

	// wait until every result is back, then let the engine settle
	task automatic drain_results();
		in_valid <= 1'b0;
		while (span_results_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == CFG_DEGREE)
			deg_cfg = val[DEG_W-1:0];
		else
			last_cfg = val[IDX_W-1:0];
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input int p, input int m);
		drain_results();
		if ($urandom_range(0, 1)) begin
			write_reg(CFG_DEGREE, CFG_DATA_W'(p));
			write_reg(CFG_LAST_KNOT, CFG_DATA_W'(m));
		end else begin
			write_reg(CFG_LAST_KNOT, CFG_DATA_W'(m));
			write_reg(CFG_DEGREE, CFG_DATA_W'(p));
		end
	endtask

	// fill slots 0..m; sorted kinds keep p+1 equal end knots when clamped
	task automatic load_knot_vector(input int p, input int m, input vec_kind_t kind);
		logic signed [KNOT_W-1:0] vals [0:KNOT_SLOTS-1];
		longint v, step_max;
		int a;
		bit descending;
		descending = $urandom_range(0, 1);
		step_max = 1 << 20;
		v = longint'($urandom_range(0, 32'h4000_0000)) - 64'sd1073741824;
		if (kind == VEC_FULL_RANGE) begin
			v = longint'(Q_MIN);
			step_max = 64'sd4294967295 / m;
		end
		for (int i = 0; i <= m; i++) begin
			if (kind == VEC_SCRAMBLED) begin
				vals[i] = $urandom;
			end else begin
				if (i > 0 && (kind == VEC_OPEN || (i > p && i <= m - p)))
					v += ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, step_max);
				vals[i] = v[KNOT_W-1:0];
			end
		end
		for (int i = 0; i <= m; i++) begin
			a = descending ? m - i : i;
			knot_write(a, vals[a]);
		end
	endtask

	// parameter value for a span query: inside the knot range, on a knot, or anywhere
	function automatic longint pick_param(input int p, input int m);
		logic [63:0] r;
		longint lo, hi;
		int n, j;
		r = {$urandom, $urandom};
		if (m < 2 * p + 1) return longint'($signed(r[31:0]));
		n = m - p - 1;
		lo = knot_rd(p);
		hi = knot_rd(n + 1);
		j = $urandom_range(p, n + 1);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return (hi > lo) ? lo + longint'(r % 64'(hi - lo + 1)) : lo;
			4, 5: return knot_rd(j);
			6: return knot_rd(j) + ($urandom_range(0, 1) ? 1 : -1);
			7: return $urandom_range(0, 1) ? longint'(Q_MIN) : longint'(Q_MAX);
			default: return longint'($signed(r[31:0]));
		endcase
	endfunction

	// ---------------- tests ----------------

	// every slot gets a strictly increasing value, so any read is of a written slot
	task automatic test_fill_knot_store();
		for (int i = 0; i < KNOT_SLOTS; i++)
			knot_write(i, (i - 32) * 65536 + 3 * i);
		drain_results();
	endtask

	// degree 3, last knot 7 straight out of reset
	task automatic test_reset_settings();
		span_query(longint'(Q_MIN));
		span_query(knot_rd(3));
		span_query(knot_rd(3) + 1);
		span_query(knot_rd(4));
		span_query(longint'(Q_MAX));
		colloc_query(0);
		colloc_query(4);
		colloc_query(5);
		colloc_query(63);
		reserved_op();
		drain_results();
	endtask

	// smallest and largest degree and knot count, legal and too few knots
	task automatic test_setting_extremes();
		set_config(1, 2);
		span_query(0);
		colloc_query(0);
		set_config(1, 3);
		span_query(knot_rd(1) + 5);
		colloc_query(2);
		set_config(7, 63);
		span_query(pick_param(7, 63));
		colloc_query(56);
		colloc_query(57);
		set_config(7, 14);
		span_query(knot_rd(10));
		drain_results();
	endtask

	// knots out of order, with extreme knot values
	task automatic test_unsorted_knots();
		set_config(1, 7);
		knot_write(3, 32'sh4000_0000);
		knot_write(4, Q_MIN);
		knot_write(6, Q_MAX);
		span_query(256);
		colloc_query(3);
		drain_results();
	endtask

	task automatic test_random_phases();
		int p, m, r, node;
		vec_kind_t kind;
		while (items_sent < ITEM_GOAL) begin
			p = $urandom_range(1, MAX_DEG);
			case ($urandom_range(0, 7))
				0: m = $urandom_range(2, 2 * p);
				1, 2, 3: m = $urandom_range(2 * p + 1, 2 * p + 9);
				default: m = $urandom_range(2 * p + 1, KNOT_SLOTS - 1);
			endcase
			set_config(p, m);
			sender_steady = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 9);
			if (r < 5)
				kind = VEC_CLAMPED;
			else if (r < 7)
				kind = VEC_OPEN;
			else if (r < 9)
				kind = VEC_FULL_RANGE;
			else
				kind = VEC_SCRAMBLED;
			load_knot_vector(p, m, kind);
			repeat ($urandom_range(15, 50)) begin
				r = $urandom_range(0, 99);
				if (r < 45) begin
					span_query(pick_param(p, m));
				end else if (r < 85) begin
					if (m >= p && $urandom_range(0, 4) != 0)
						node = $urandom_range(0, m - p);
					else
						node = $urandom_range(0, KNOT_SLOTS - 1);
					colloc_query(node);
				end else if (r < 93) begin
					knot_write($urandom_range(0, KNOT_SLOTS - 1), $urandom);
				end else begin
					reserved_op();
				end
			end
			drain_results();
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_item <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_fill_knot_store();
		test_reset_settings();
		test_setting_extremes();
		test_unsorted_knots();
		test_random_phases();

		drain_results();
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+design
design/ksg_pkg.sv
design/ksg_ram.sv
design/ksg_div.sv
design/knot_span_greville_engine_core.sv
bench/tb_knot_span_greville_engine_core.sv
